### design/rpat_pkg.sv
// Shared types, codes and sizes for the recent peer address table.
// No dependencies; every other file in the design uses this package.
package rpat_pkg;

    localparam int MAX_ENTRIES_DEF = 8;

    localparam int CAP_W     = 4;
    localparam int TMO_W     = 16;
    localparam int TIME_W    = 32;
    localparam int ADDR_W    = 64;
    localparam int PORT_W    = 16;
    localparam int RAND_W    = 32;
    localparam int SLOT_W    = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1);
    localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(30);

    // remainder unit: bits of the random word retired per cycle
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = RAND_W / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 1'b0,
        CFG_TIMEOUT  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        FUNC_UPDATE = 1'b0,
        FUNC_CHOOSE = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_REFRESHED = 3'd0,
        ST_APPENDED  = 3'd1,
        ST_REPLACED  = 3'd2,
        ST_LATEST    = 3'd3,
        ST_RANDOM    = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        SEL_ZERO   = 3'd0,
        SEL_HIT    = 3'd1,
        SEL_APPEND = 3'd2,
        SEL_OLDEST = 3'd3,
        SEL_LATEST = 3'd4
    } t_sel;

    typedef struct packed {
        logic [0:0]        func;
        logic [TIME_W-1:0] now;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [PORT_W-1:0] port_in;
        logic [0:0]        ipv6_in;
        logic [RAND_W-1:0] rand_value;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] out_addr_high;
        logic [ADDR_W-1:0] out_addr_low;
        logic [PORT_W-1:0] out_port;
        logic [0:0]        out_ipv6;
        logic [SLOT_W-1:0] slot_index;
    } t_res;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [PORT_W-1:0] port;
        logic              ipv6;
        logic [TIME_W-1:0] last_seen;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic    load_item;
        logic    scan_start;
        logic    scan_pass2;
        logic    mod_start;
        logic    out_load;
        logic    tbl_write;
        logic    count_inc;
        t_sel    sel;
        t_status status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_choose;
        logic scan_done;
        logic mod_done;
        logic found;
        logic empty;
        logic room;
        logic few_fresh;
        logic out_free;
    } t_sts;

endpackage

### design/recent_peer_address_table.sv
// Top level of the recent peer address table: controller plus datapath.
// Uses rpat_pkg; instantiates rpat_ctrl and rpat_dp.
//
//  channel   handshake                     payload
//  request   i_in_valid / o_in_stall       i_in_req    (rpat_pkg::t_req)
//  result    o_out_valid / i_out_stall     o_out_res   (rpat_pkg::t_res)
//  config    i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One request at a time. An update makes one pass over the held entries, as
// does a choose with at most one fresh entry; a choose over two or more fresh
// entries makes two passes over the single read port of the entry memory, with
// the remainder stage between the two passes.
// Synchronous active-low reset empties the table; entry contents need none.
// A stalled result waits in the output register while the next request runs.
module recent_peer_address_table #(
    parameter int MAX_ENTRIES = rpat_pkg::MAX_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  rpat_pkg::t_req                 i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output rpat_pkg::t_res                 o_out_res,
    input  logic                           i_cfg_we,
    input  logic [rpat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rpat_pkg::CFG_W-1:0]     i_cfg_data
);

    rpat_pkg::t_cmd cmd;
    rpat_pkg::t_sts sts;
    logic           busy;
    logic           accept;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    rpat_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    rpat_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_in_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

endmodule

### design/rpat_mod.sv
// Iterative remainder unit: random word modulo the fresh-entry count.
// Uses rpat_pkg for widths and step counts.
module rpat_mod #(
    parameter int DIV_W = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rpat_pkg::RAND_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic [DIV_W-1:0]          o_rem
);

    logic                              r_busy;
    logic [rpat_pkg::MOD_CNT_W-1:0]    r_cnt;
    logic [rpat_pkg::RAND_W-1:0]       r_q;
    logic [DIV_W-1:0]                  r_rem;
    logic [DIV_W-1:0]                  r_div;
    logic [rpat_pkg::RAND_W-1:0]       n_q;
    logic [DIV_W:0]                    n_t;

    // restoring remainder, MOD_BITS quotient bits per cycle
    always_comb begin
        n_q = r_q;
        n_t = {1'b0, r_rem};
        for (int s = 0; s < rpat_pkg::MOD_BITS; s++) begin
            n_t = {n_t[DIV_W-1:0], n_q[rpat_pkg::RAND_W-1]};
            n_q = {n_q[rpat_pkg::RAND_W-2:0], 1'b0};
            if (n_t >= {1'b0, r_div}) begin
                n_t = n_t - {1'b0, r_div};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= rpat_pkg::MOD_CNT_W'(rpat_pkg::MOD_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == rpat_pkg::MOD_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_t[DIV_W-1:0];
        end
    end

    assign o_done = !r_busy;
    assign o_rem  = r_rem;

endmodule

### design/rpat_dp.sv
// Datapath: config registers, entry memory, scan evaluation, result register.
// Uses rpat_pkg types; instantiates rpat_mod; driven by rpat_ctrl commands.
module rpat_dp #(
    parameter int MAX_ENTRIES = rpat_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rpat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rpat_pkg::CFG_W-1:0]    i_cfg_data,
    input  rpat_pkg::t_req                i_req,
    input  rpat_pkg::t_cmd                i_cmd,
    output rpat_pkg::t_sts                o_sts,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output rpat_pkg::t_res                o_out_res
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EW = (CW > rpat_pkg::CAP_W) ? CW : rpat_pkg::CAP_W;

    logic [rpat_pkg::CAP_W-1:0] r_capacity;
    logic [rpat_pkg::TMO_W-1:0] r_timeout;
    rpat_pkg::t_req             r_item;
    logic [CW-1:0]              r_count;

    rpat_pkg::t_entry           r_mem [MAX_ENTRIES];
    rpat_pkg::t_entry           r_rd_data;
    rpat_pkg::t_entry           wr_data;
    logic [IW-1:0]              rd_addr;
    logic [IW-1:0]              slot;

    logic [CW-1:0]              r_scan_idx;
    logic                       r_scan_act;
    logic                       r_eval_vld;
    logic [IW-1:0]              r_eval_idx;
    logic                       r_pass2;
    logic                       r_found;
    logic [IW-1:0]              r_hit_idx;
    logic [IW-1:0]              r_old_idx;
    logic [IW-1:0]              r_lat_idx;
    logic [rpat_pkg::TIME_W-1:0] r_old_ts;
    logic [rpat_pkg::TIME_W-1:0] r_lat_ts;
    logic [CW-1:0]              r_fresh_cnt;
    logic [CW-1:0]              r_seen;

    logic                       r_out_vld;
    rpat_pkg::t_res             r_out;

    logic [rpat_pkg::TIME_W-1:0] age;
    logic                       fresh;
    logic                       match;
    logic                       is_choose;
    logic [EW-1:0]              eff_cap;
    logic                       mod_done;
    logic [CW-1:0]              mod_rem;
    logic                       with_addr;
    logic                       out_free;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= rpat_pkg::CAP_RESET;
            r_timeout  <= rpat_pkg::TMO_RESET;
        end else if (i_cfg_we) begin
            case (rpat_pkg::t_cfg_idx'(i_cfg_idx))
                rpat_pkg::CFG_CAPACITY: r_capacity <= i_cfg_data[rpat_pkg::CAP_W-1:0];
                rpat_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_data[rpat_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // capacity 0 behaves as 1, values above the table depth as the depth
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = EW'(1);
        end else if (EW'(r_capacity) > EW'(MAX_ENTRIES)) begin
            eff_cap = EW'(MAX_ENTRIES);
        end else begin
            eff_cap = EW'(r_capacity);
        end
    end

    assign is_choose = (r_item.func == rpat_pkg::FUNC_CHOOSE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.count_inc) begin
            r_count <= r_count + 1'b1;
        end
    end

    // slot chosen by the controller for write-back and result
    always_comb begin
        case (i_cmd.sel)
            rpat_pkg::SEL_HIT:    slot = r_hit_idx;
            rpat_pkg::SEL_APPEND: slot = r_count[IW-1:0];
            rpat_pkg::SEL_OLDEST: slot = r_old_idx;
            rpat_pkg::SEL_LATEST: slot = r_lat_idx;
            default:              slot = '0;
        endcase
    end

    assign rd_addr = r_scan_act ? r_scan_idx[IW-1:0] : slot;

    always_comb begin
        wr_data.addr_high = r_item.addr_high;
        wr_data.addr_low  = r_item.addr_low;
        wr_data.port      = r_item.port_in;
        wr_data.ipv6      = r_item.ipv6_in;
        wr_data.last_seen = r_item.now;
    end

    // a refresh rewrites the same address, so every update writes a whole entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_write) begin
            r_mem[slot] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // evaluation of the entry read in the previous cycle
    assign age   = r_item.now - r_rd_data.last_seen;
    assign fresh = (age <= rpat_pkg::TIME_W'(r_timeout));
    assign match = (r_rd_data.ipv6 == r_item.ipv6_in) &&
                   (r_rd_data.addr_high == r_item.addr_high) &&
                   (r_rd_data.addr_low == r_item.addr_low) &&
                   (r_rd_data.port == r_item.port_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_act <= 1'b0;
            r_eval_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_scan_act <= (r_count != '0);
            r_eval_vld <= 1'b0;
        end else begin
            r_eval_vld <= r_scan_act;
            if (r_scan_act && (r_scan_idx + 1'b1 == r_count)) begin
                r_scan_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_idx  <= '0;
            r_pass2     <= i_cmd.scan_pass2;
            r_found     <= 1'b0;
            r_fresh_cnt <= '0;
            r_seen      <= '0;
        end else begin
            r_eval_idx <= r_scan_idx[IW-1:0];
            if (r_scan_act) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (r_eval_vld) begin
                // strict compares keep the first slot on ties
                if (r_eval_idx == '0 || r_rd_data.last_seen < r_old_ts) begin
                    r_old_ts  <= r_rd_data.last_seen;
                    r_old_idx <= r_eval_idx;
                end
                if (r_eval_idx == '0 || r_rd_data.last_seen > r_lat_ts) begin
                    r_lat_ts  <= r_rd_data.last_seen;
                    r_lat_idx <= r_eval_idx;
                end
                if (!r_pass2) begin
                    if (!is_choose && match && !r_found) begin
                        r_found   <= 1'b1;
                        r_hit_idx <= r_eval_idx;
                    end
                    if (is_choose && fresh) begin
                        r_fresh_cnt <= r_fresh_cnt + 1'b1;
                    end
                end else if (fresh && !r_found) begin
                    if (r_seen == mod_rem) begin
                        r_found   <= 1'b1;
                        r_hit_idx <= r_eval_idx;
                    end else begin
                        r_seen <= r_seen + 1'b1;
                    end
                end
            end
        end
    end

    rpat_mod #(
        .DIV_W (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (r_item.rand_value),
        .i_divisor  (r_fresh_cnt),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // result register
    assign out_free  = !r_out_vld || !i_out_stall;
    assign with_addr = (i_cmd.status == rpat_pkg::ST_LATEST) ||
                       (i_cmd.status == rpat_pkg::ST_RANDOM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status        <= i_cmd.status;
            r_out.out_addr_high <= with_addr ? r_rd_data.addr_high : '0;
            r_out.out_addr_low  <= with_addr ? r_rd_data.addr_low : '0;
            r_out.out_port      <= with_addr ? r_rd_data.port : '0;
            r_out.out_ipv6      <= with_addr ? r_rd_data.ipv6 : 1'b0;
            r_out.slot_index    <= rpat_pkg::SLOT_W'(slot);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out;

    always_comb begin
        o_sts.is_choose = is_choose;
        o_sts.scan_done = !r_scan_act && !r_eval_vld;
        o_sts.mod_done  = mod_done;
        o_sts.found     = r_found;
        o_sts.empty     = (r_count == '0);
        o_sts.room      = (EW'(r_count) < eff_cap);
        o_sts.few_fresh = (r_fresh_cnt <= CW'(1));
        o_sts.out_free  = out_free;
    end

endmodule

### design/rpat_ctrl.sv
// Controller: sequences scans, the remainder unit, fetch and result load.
// Uses rpat_pkg command/status structs; drives rpat_dp.
module rpat_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  rpat_pkg::t_sts i_sts,
    output rpat_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN1  = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_MOD    = 7'b0001000,
        S_SCAN2  = 7'b0010000,
        S_FETCH  = 7'b0100000,
        S_LOAD   = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    rpat_pkg::t_sel    r_sel, n_sel;
    rpat_pkg::t_status r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_sel    = r_sel;
        n_status = r_status;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_item  = i_accept;
                o_cmd.scan_start = i_accept;
                if (i_accept) begin
                    n_state = S_SCAN1;
                end
            end
            S_SCAN1: begin
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_sts.is_choose) begin
                    n_state = S_LOAD;
                    if (i_sts.found) begin
                        n_status = rpat_pkg::ST_REFRESHED;
                        n_sel    = rpat_pkg::SEL_HIT;
                    end else if (i_sts.room) begin
                        n_status = rpat_pkg::ST_APPENDED;
                        n_sel    = rpat_pkg::SEL_APPEND;
                    end else begin
                        n_status = rpat_pkg::ST_REPLACED;
                        n_sel    = rpat_pkg::SEL_OLDEST;
                    end
                end else if (i_sts.empty) begin
                    n_status = rpat_pkg::ST_EMPTY;
                    n_sel    = rpat_pkg::SEL_ZERO;
                    n_state  = S_LOAD;
                end else if (i_sts.few_fresh) begin
                    n_status = rpat_pkg::ST_LATEST;
                    n_sel    = rpat_pkg::SEL_LATEST;
                    n_state  = S_FETCH;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_pass2 = 1'b1;
                    n_state          = S_SCAN2;
                end
            end
            S_SCAN2: begin
                // k is below the fresh count, so the pass always finds a hit
                if (i_sts.scan_done) begin
                    n_status = rpat_pkg::ST_RANDOM;
                    n_sel    = rpat_pkg::SEL_HIT;
                    n_state  = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.tbl_write = !i_sts.is_choose;
                    o_cmd.count_inc = (r_status == rpat_pkg::ST_APPENDED);
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.sel    = r_sel;
        o_cmd.status = r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sel    <= rpat_pkg::SEL_ZERO;
            r_status <= rpat_pkg::ST_EMPTY;
        end else begin
            r_state  <= n_state;
            r_sel    <= n_sel;
            r_status <= n_status;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### verif/testbench.sv
// Self-checking testbench for recent_peer_address_table: a behavioral copy of the
// peer table predicts every result, with random idling on both request and result sides.
// Depends on rpat_pkg and the recent_peer_address_table RTL.
module testbench;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    rpat_pkg::t_req                 i_in_req = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    rpat_pkg::t_res                 o_out_res;
    logic                           i_cfg_we = 1'b0;
    logic [rpat_pkg::CFG_IDX_W-1:0] i_cfg_idx = rpat_pkg::CFG_CAPACITY;
    logic [rpat_pkg::CFG_W-1:0]     i_cfg_data = '0;

    recent_peer_address_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_res  (o_out_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of the peer table and its registers
    rpat_pkg::t_entry               shadow_peers [rpat_pkg::MAX_ENTRIES_DEF];
    int                             peer_count = 0;
    logic [rpat_pkg::CAP_W-1:0]     cap_reg = rpat_pkg::CAP_RESET;
    logic [rpat_pkg::TMO_W-1:0]     tmo_reg = rpat_pkg::TMO_RESET;

    rpat_pkg::t_res                 pending_results [$];
    int                             mismatch_count = 0;

    // stimulus state
    rpat_pkg::t_entry               peer_pool [16];
    logic [rpat_pkg::TIME_W-1:0]    peer_now = '0;
    bit                             send_burst = 1'b0;
    bit                             recv_burst = 1'b0;
    int                             stall_left = 0;

    function automatic rpat_pkg::t_res predict_peer_result(rpat_pkg::t_req r);
        rpat_pkg::t_res res;
        int n, cap, hit, pick, fresh, k, seen;
        logic [rpat_pkg::TIME_W-1:0] age;
        res = '0;
        n = peer_count;
        cap = (cap_reg == '0) ? 1 :
              (int'(cap_reg) > rpat_pkg::MAX_ENTRIES_DEF) ? rpat_pkg::MAX_ENTRIES_DEF :
              int'(cap_reg);
        if (r.func == rpat_pkg::FUNC_UPDATE) begin
            hit = -1;
            for (int i = 0; i < n; i++)
                if (hit < 0 && shadow_peers[i].ipv6 == r.ipv6_in &&
                    shadow_peers[i].addr_high == r.addr_high &&
                    shadow_peers[i].addr_low == r.addr_low &&
                    shadow_peers[i].port == r.port_in)
                    hit = i;
            if (hit >= 0) begin
                shadow_peers[hit].last_seen = r.now;
                res.status = rpat_pkg::ST_REFRESHED;
                pick = hit;
            end else begin
                if (n < cap) begin
                    pick = n;
                    peer_count = n + 1;
                    res.status = rpat_pkg::ST_APPENDED;
                end else begin
                    // plain unsigned compare, lowest slot wins ties
                    pick = 0;
                    for (int i = 1; i < n; i++)
                        if (shadow_peers[i].last_seen < shadow_peers[pick].last_seen) pick = i;
                    res.status = rpat_pkg::ST_REPLACED;
                end
                shadow_peers[pick] = '{addr_high: r.addr_high, addr_low: r.addr_low,
                                       port: r.port_in, ipv6: r.ipv6_in, last_seen: r.now};
            end
            res.slot_index = pick[rpat_pkg::SLOT_W-1:0];
        end else if (n == 0) begin
            res.status = rpat_pkg::ST_EMPTY;
        end else begin
            pick = 0;
            fresh = 0;
            for (int i = 0; i < n; i++) begin
                if (shadow_peers[i].last_seen > shadow_peers[pick].last_seen) pick = i;
                age = r.now - shadow_peers[i].last_seen;
                if (age <= rpat_pkg::TIME_W'(tmo_reg)) fresh++;
            end
            res.status = rpat_pkg::ST_LATEST;
            if (fresh > 1) begin
                k = int'(r.rand_value % rpat_pkg::RAND_W'(fresh));
                seen = 0;
                for (int i = 0; i < n; i++) begin
                    age = r.now - shadow_peers[i].last_seen;
                    if (age <= rpat_pkg::TIME_W'(tmo_reg)) begin
                        if (seen == k) begin
                            pick = i;
                            res.status = rpat_pkg::ST_RANDOM;
                        end
                        seen++;
                    end
                end
            end
            res.out_addr_high = shadow_peers[pick].addr_high;
            res.out_addr_low  = shadow_peers[pick].addr_low;
            res.out_port      = shadow_peers[pick].port;
            res.out_ipv6      = shadow_peers[pick].ipv6;
            res.slot_index    = pick[rpat_pkg::SLOT_W-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s differs: got %h, want %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // result side: check each accepted result, then draw the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result status", 64'(o_out_res.status), '0);
            end else begin
                rpat_pkg::t_res want;
                want = pending_results.pop_front();
                if (o_out_res.status != want.status)
                    report_mismatch("status", 64'(o_out_res.status), 64'(want.status));
                if (o_out_res.out_addr_high != want.out_addr_high)
                    report_mismatch("out_addr_high", o_out_res.out_addr_high, want.out_addr_high);
                if (o_out_res.out_addr_low != want.out_addr_low)
                    report_mismatch("out_addr_low", o_out_res.out_addr_low, want.out_addr_low);
                if (o_out_res.out_port != want.out_port)
                    report_mismatch("out_port", 64'(o_out_res.out_port), 64'(want.out_port));
                if (o_out_res.out_ipv6 != want.out_ipv6)
                    report_mismatch("out_ipv6", 64'(o_out_res.out_ipv6), 64'(want.out_ipv6));
                if (o_out_res.slot_index != want.slot_index)
                    report_mismatch("slot_index", 64'(o_out_res.slot_index),
                                    64'(want.slot_index));
            end
            if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
            stall_left = recv_burst ? 0 : int'($urandom_range(0, 15));
            i_out_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= (stall_left != 0);
        end
    end

    // valid stays high after acceptance; the next call lowers it only for a gap
    task automatic send_request(rpat_pkg::t_req r);
        int gap;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : int'($urandom_range(0, 15));
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_peer_result(r));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_config(rpat_pkg::t_cfg_idx idx, logic [rpat_pkg::CFG_W-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == rpat_pkg::CFG_CAPACITY) cap_reg = value[rpat_pkg::CAP_W-1:0];
        else tmo_reg = value[rpat_pkg::TMO_W-1:0];
    endtask

    function automatic rpat_pkg::t_req make_request(rpat_pkg::t_func f,
                                                    logic [rpat_pkg::TIME_W-1:0] t,
                                                    logic [rpat_pkg::ADDR_W-1:0] ah,
                                                    logic [rpat_pkg::ADDR_W-1:0] al,
                                                    logic [rpat_pkg::PORT_W-1:0] p,
                                                    logic v6,
                                                    logic [rpat_pkg::RAND_W-1:0] rv);
        rpat_pkg::t_req r;
        r.func       = f;
        r.now        = t;
        r.addr_high  = ah;
        r.addr_low   = al;
        r.port_in    = p;
        r.ipv6_in    = v6;
        r.rand_value = rv;
        return r;
    endfunction

    function automatic rpat_pkg::t_entry random_peer();
        rpat_pkg::t_entry p;
        p.ipv6      = 1'($urandom_range(0, 1));
        // IPv4 mostly zero above bit 31, occasionally not
        p.addr_high = (p.ipv6 || $urandom_range(0, 7) == 0) ? {$urandom, $urandom} : '0;
        p.addr_low  = {(p.ipv6 || $urandom_range(0, 7) == 0) ? $urandom : 32'd0, $urandom};
        p.port      = rpat_pkg::PORT_W'($urandom);
        p.last_seen = '0;
        return p;
    endfunction

    // groups of four near-identical peers so partial matches are common
    function automatic void refill_peer_pool();
        for (int i = 0; i < 16; i++) begin
            if (i % 4 == 0) begin
                peer_pool[i] = random_peer();
            end else begin
                peer_pool[i] = peer_pool[i-1];
                case ($urandom_range(0, 3))
                    0: peer_pool[i].port ^= 16'd1 << $urandom_range(0, 15);
                    1: peer_pool[i].ipv6 = ~peer_pool[i].ipv6;
                    2: peer_pool[i].addr_low ^= 64'd1 << $urandom_range(0, 63);
                    default: peer_pool[i].addr_high ^= 64'd1 << $urandom_range(0, 63);
                endcase
            end
        end
    endfunction

    function automatic rpat_pkg::t_req random_request();
        rpat_pkg::t_entry p;
        rpat_pkg::t_func  f;
        case ($urandom_range(0, 19))
            0, 1, 2: ;
            3, 4, 5, 6, 7, 8, 9, 10: peer_now += $urandom_range(1, 5);
            18: peer_now = $urandom;
            19: peer_now = 32'hFFFF_FFFF - $urandom_range(0, 20);
            default: peer_now += $urandom_range(0, int'(tmo_reg) + int'(tmo_reg) / 2 + 2);
        endcase
        if ($urandom_range(0, 4) == 0) p = random_peer();
        else p = peer_pool[$urandom_range(0, 15)];
        f = $urandom_range(0, 1) ? rpat_pkg::FUNC_CHOOSE : rpat_pkg::FUNC_UPDATE;
        return make_request(f, peer_now, p.addr_high, p.addr_low, p.port, p.ipv6, $urandom);
    endfunction

    // reset settings: one slot, 30 s timeout
    task automatic test_single_slot();
        send_request(make_request(rpat_pkg::FUNC_CHOOSE, 32'd0, '0, '0, '0, 1'b0,
                                  32'hFFFF_FFFF));
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'd0, '0, 64'h0A00_0001, 16'd1000,
                                  1'b0, '0));
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'd5, '0, 64'h0A00_0001, 16'd1000,
                                  1'b0, '0));
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'd6, '0, 64'h0A00_0002, 16'd1000,
                                  1'b0, '0));
        send_request(make_request(rpat_pkg::FUNC_CHOOSE, 32'd40, '0, '0, '0, 1'b0, '0));
        write_config(rpat_pkg::CFG_CAPACITY, 16'hFFF0);   // capacity 0 behaves as 1
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'd7, '0, 64'h0A00_0003, 16'd2000,
                                  1'b0, '0));
    endtask

    // fill all eight slots across the time wrap, with near-duplicate addresses and ties
    task automatic test_full_table();
        write_config(rpat_pkg::CFG_CAPACITY, 16'h000F);   // above the table size
        write_config(rpat_pkg::CFG_TIMEOUT, 16'hFFFF);
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'hFFFF_FFF0, '1, '1, 16'hFFFF,
                                  1'b1, '0));
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'hFFFF_FFF0, 64'h1, 64'hC0A8_0001,
                                  16'd53, 1'b0, '0));
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'hFFFF_FFF0, 64'h1, 64'hC0A8_0001,
                                  16'd53, 1'b1, '0));
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'hFFFF_FFF1, 64'h1, 64'hC0A8_0001,
                                  16'd54, 1'b0, '0));
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0));
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'd0, '0, 64'h0A00_0004, 16'd7,
                                  1'b0, '0));
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'd0, '0, 64'h0A00_0005, 16'd7,
                                  1'b0, '0));
        send_request(make_request(rpat_pkg::FUNC_CHOOSE, 32'h10, '0, '0, '0, 1'b0,
                                  32'hFFFF_FFFF));
        send_request(make_request(rpat_pkg::FUNC_CHOOSE, 32'h10, '0, '0, '0, 1'b0, 32'd0));
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'h11, '0, 64'h0A00_0006, 16'd9,
                                  1'b0, '0));
    endtask

    // zero timeout, then capacity dropped below the number of held entries
    task automatic test_timeout_and_shrink();
        write_config(rpat_pkg::CFG_TIMEOUT, 16'h0000);
        send_request(make_request(rpat_pkg::FUNC_CHOOSE, 32'h11, '0, '0, '0, 1'b0, $urandom));
        send_request(make_request(rpat_pkg::FUNC_CHOOSE, 32'h8000_0000, '0, '0, '0, 1'b0,
                                  $urandom));
        write_config(rpat_pkg::CFG_CAPACITY, 16'h0002);
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'h12, '0, 64'h0A00_0007, 16'd11,
                                  1'b0, '0));
        send_request(make_request(rpat_pkg::FUNC_UPDATE, 32'h13, 64'h1, 64'hC0A8_0001, 16'd54,
                                  1'b0, '0));
    endtask

    task automatic test_random_traffic();
        logic [rpat_pkg::CAP_W-1:0] caps [10] = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15,
                                                  4'd2, 4'd5, 4'd12, 4'd4, 4'd7};
        logic [rpat_pkg::TMO_W-1:0] tmo;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: tmo = 16'd30;
                1: tmo = 16'd0;
                2: tmo = 16'hFFFF;
                3: tmo = rpat_pkg::TMO_W'($urandom_range(1, 8));
                default: tmo = rpat_pkg::TMO_W'($urandom);
            endcase
            write_config(rpat_pkg::CFG_CAPACITY, {12'($urandom), caps[ph]});
            write_config(rpat_pkg::CFG_TIMEOUT, tmo);
            refill_peer_pool();
            repeat (95) send_request(random_request());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_slot();
        test_full_table();
        test_timeout_and_shrink();
        test_random_traffic();
        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
design/rpat_pkg.sv
design/rpat_mod.sv
design/rpat_dp.sv
design/rpat_ctrl.sv
design/recent_peer_address_table.sv
verif/testbench.sv
